>>> rtl/core/pcft_pkg.sv
// ----------------------------------------------------------------------------
// Pair collision filter table package
// Shared command codes, status codes and the record types that pass
// between the cells of the rule chain.
// ----------------------------------------------------------------------------
package pcft_pkg;

    localparam int ID_W   = 16;
    localparam int PORT_W = 16;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    localparam logic [1:0] KIND_FF = 2'd0;
    localparam logic [1:0] KIND_PP = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic            vld;
        t_cmd            cmd;
        logic [1:0]      kind;
        logic            allow;
        logic [ID_W-1:0] rid;
        logic            done;
        logic            hit_allow;
    } t_probe;

    typedef struct packed {
        logic            vld;
        logic [1:0]      kind;
        logic            allow;
        logic [ID_W-1:0] ident;
    } t_entry;

endpackage

>>> rtl/core/pcft_cell.sv
// ----------------------------------------------------------------------------
// Rule cell
// Holds one rule of the table and acts on the command that passes through
// it, then hands the command on to the next cell in the cycle after.
// ----------------------------------------------------------------------------
module pcft_cell
    import pcft_pkg::*;
#(
    parameter int KEY_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_probe           i_probe,
    input  logic [KEY_W-1:0] i_pkey_a,
    input  logic [KEY_W-1:0] i_pkey_b,
    input  t_entry           i_nxt_ent,
    input  logic [KEY_W-1:0] i_nxt_key_a,
    input  logic [KEY_W-1:0] i_nxt_key_b,
    output t_probe           o_probe,
    output logic [KEY_W-1:0] o_pkey_a,
    output logic [KEY_W-1:0] o_pkey_b,
    output t_entry           o_ent,
    output logic [KEY_W-1:0] o_key_a,
    output logic [KEY_W-1:0] o_key_b
);

    t_entry           r_ent, n_ent;
    logic [KEY_W-1:0] r_key_a, n_key_a;
    logic [KEY_W-1:0] r_key_b, n_key_b;
    t_probe           r_probe, n_probe;
    logic [KEY_W-1:0] r_pkey_a, r_pkey_b;
    logic             direct, swapped, hit, id_match;

    always_comb begin
        n_ent   = r_ent;
        n_key_a = r_key_a;
        n_key_b = r_key_b;
        n_probe = i_probe;

        direct   = (r_key_a == i_pkey_a) && (r_key_b == i_pkey_b);
        swapped  = (r_key_a == i_pkey_b) && (r_key_b == i_pkey_a) &&
                   ((i_probe.kind == KIND_FF) || (i_probe.kind == KIND_PP));
        hit      = !i_probe.done && r_ent.vld && (r_ent.kind == i_probe.kind) &&
                   (direct || swapped);
        id_match = !i_probe.done && r_ent.vld && (r_ent.ident == i_probe.rid);

        if (i_probe.vld) begin
            case (i_probe.cmd)
                CMD_ADD: begin
                    if (!i_probe.done && !r_ent.vld) begin
                        n_ent.vld    = 1'b1;
                        n_ent.kind   = i_probe.kind;
                        n_ent.allow  = i_probe.allow;
                        n_ent.ident  = i_probe.rid;
                        n_key_a      = i_pkey_a;
                        n_key_b      = i_pkey_b;
                        n_probe.done = 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (i_probe.done || id_match) begin
                        n_ent        = i_nxt_ent;
                        n_key_a      = i_nxt_key_a;
                        n_key_b      = i_nxt_key_b;
                        n_probe.done = 1'b1;
                    end
                end
                CMD_QUERY: begin
                    if (hit) begin
                        n_probe.done      = 1'b1;
                        n_probe.hit_allow = r_ent.allow;
                    end
                end
                CMD_CLEAR: begin
                    n_ent.vld = 1'b0;
                end
                default: begin
                    n_ent = r_ent;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent.kind  <= n_ent.kind;
        r_ent.allow <= n_ent.allow;
        r_ent.ident <= n_ent.ident;
        r_key_a     <= n_key_a;
        r_key_b     <= n_key_b;
        r_pkey_a    <= i_pkey_a;
        r_pkey_b    <= i_pkey_b;
        r_probe.cmd       <= n_probe.cmd;
        r_probe.kind      <= n_probe.kind;
        r_probe.allow     <= n_probe.allow;
        r_probe.rid       <= n_probe.rid;
        r_probe.done      <= n_probe.done;
        r_probe.hit_allow <= n_probe.hit_allow;
        if (!i_rst_n) begin
            r_ent.vld   <= 1'b0;
            r_probe.vld <= 1'b0;
        end else begin
            r_ent.vld   <= n_ent.vld;
            r_probe.vld <= n_probe.vld;
        end
    end

    assign o_probe  = r_probe;
    assign o_pkey_a = r_pkey_a;
    assign o_pkey_b = r_pkey_b;
    assign o_ent    = r_ent;
    assign o_key_a  = r_key_a;
    assign o_key_b  = r_key_b;

endmodule

>>> rtl/core/pair_collision_filter_table.sv
// ----------------------------------------------------------------------------
// Pair collision filter table
// Ordered table of pair rules with add, remove by id, query and clear.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low. It then walks
// down a chain of TABLE_DEPTH rule cells, one cell per cycle, and no new
// command is transferred until the result of the last one is out: busy stays
// high until the result cycle is over. Each result is shown for exactly one
// cycle with o_valid high and cannot be held off by the receiver, so it must
// be taken in that cycle.
module pair_collision_filter_table
    import pcft_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_cmd,
    input  logic [1:0]        i_kind,
    input  logic [PORT_W-1:0] i_key_a,
    input  logic [PORT_W-1:0] i_key_b,
    input  logic              i_allow,
    input  logic [ID_W-1:0]   i_rule_id,
    output logic              o_valid,
    output logic [ID_W-1:0]   o_new_id,
    output logic              o_collide,
    output logic              o_matched,
    output logic [1:0]        o_status
);

    localparam int KW = (KEY_BITS < PORT_W) ? KEY_BITS : PORT_W;

    t_probe          probe_in  [TABLE_DEPTH];
    t_probe          probe_out [TABLE_DEPTH];
    logic [KW-1:0]   pka_in    [TABLE_DEPTH];
    logic [KW-1:0]   pkb_in    [TABLE_DEPTH];
    logic [KW-1:0]   pka_out   [TABLE_DEPTH];
    logic [KW-1:0]   pkb_out   [TABLE_DEPTH];
    t_entry          ent       [TABLE_DEPTH];
    logic [KW-1:0]   eka       [TABLE_DEPTH];
    logic [KW-1:0]   ekb       [TABLE_DEPTH];
    t_entry          nxt_ent   [TABLE_DEPTH];
    logic [KW-1:0]   nxt_ka    [TABLE_DEPTH];
    logic [KW-1:0]   nxt_kb    [TABLE_DEPTH];

    logic            r_busy;
    logic [ID_W-1:0] r_next_ident;
    logic            accept;
    t_probe          last;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_comb begin
        probe_in[0].vld       = accept;
        probe_in[0].cmd       = t_cmd'(i_cmd);
        probe_in[0].kind      = i_kind;
        probe_in[0].allow     = i_allow;
        probe_in[0].rid       = (t_cmd'(i_cmd) == CMD_ADD) ? r_next_ident : i_rule_id;
        probe_in[0].done      = 1'b0;
        probe_in[0].hit_allow = 1'b0;
        pka_in[0]             = i_key_a[KW-1:0];
        pkb_in[0]             = i_key_b[KW-1:0];
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            if (g > 0) begin : g_link
                assign probe_in[g] = probe_out[g-1];
                assign pka_in[g]   = pka_out[g-1];
                assign pkb_in[g]   = pkb_out[g-1];
            end
            if (g < TABLE_DEPTH - 1) begin : g_nxt
                assign nxt_ent[g] = ent[g+1];
                assign nxt_ka[g]  = eka[g+1];
                assign nxt_kb[g]  = ekb[g+1];
            end else begin : g_end
                assign nxt_ent[g] = '0;
                assign nxt_ka[g]  = '0;
                assign nxt_kb[g]  = '0;
            end

            pcft_cell #(
                .KEY_W (KW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_probe     (probe_in[g]),
                .i_pkey_a    (pka_in[g]),
                .i_pkey_b    (pkb_in[g]),
                .i_nxt_ent   (nxt_ent[g]),
                .i_nxt_key_a (nxt_ka[g]),
                .i_nxt_key_b (nxt_kb[g]),
                .o_probe     (probe_out[g]),
                .o_pkey_a    (pka_out[g]),
                .o_pkey_b    (pkb_out[g]),
                .o_ent       (ent[g]),
                .o_key_a     (eka[g]),
                .o_key_b     (ekb[g])
            );
        end
    endgenerate

    assign last = probe_out[TABLE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_next_ident <= ID_W'(1);
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (last.vld) begin
                r_busy <= 1'b0;
            end
            if (last.vld && (last.cmd == CMD_ADD) && last.done) begin
                r_next_ident <= r_next_ident + ID_W'(1);
            end
        end
    end

    always_comb begin
        o_valid   = last.vld;
        o_new_id  = '0;
        o_collide = 1'b0;
        o_matched = 1'b0;
        o_status  = ST_OK;
        case (last.cmd)
            CMD_ADD: begin
                if (last.done) begin
                    o_new_id = last.rid;
                end else begin
                    o_status = ST_FULL;
                end
            end
            CMD_REMOVE: begin
                if (!last.done) begin
                    o_status = ST_NOT_FOUND;
                end
            end
            CMD_QUERY: begin
                o_matched = last.done;
                o_collide = last.done ? last.hit_allow : (last.kind == KIND_FF);
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

endmodule

>>> verif/pair_collision_filter_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pair collision filter table checker
// Watches the command and result channels of the rule table, keeps its own
// copy of the ordered rule list and the id counter, works out the answer to
// every accepted command and compares each result with the oldest answer
// still waiting.
// ----------------------------------------------------------------------------
module pair_collision_filter_table_checker
    import pcft_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [1:0]        i_cmd,
    input  logic [1:0]        i_kind,
    input  logic [PORT_W-1:0] i_key_a,
    input  logic [PORT_W-1:0] i_key_b,
    input  logic              i_allow,
    input  logic [ID_W-1:0]   i_rule_id,
    input  logic              i_valid,
    input  logic [ID_W-1:0]   i_new_id,
    input  logic              i_collide,
    input  logic              i_matched,
    input  logic [1:0]        i_status,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int FIFO_DEPTH = 16;

    typedef struct packed {
        logic [ID_W-1:0] new_id;
        logic            collide;
        logic            matched;
        logic [1:0]      status;
    } t_verdict;

    logic [1:0]        rule_kind  [TABLE_DEPTH];
    logic [PORT_W-1:0] rule_key_a [TABLE_DEPTH];
    logic [PORT_W-1:0] rule_key_b [TABLE_DEPTH];
    logic              rule_allow [TABLE_DEPTH];
    logic [ID_W-1:0]   rule_ident [TABLE_DEPTH];
    int                rule_count;
    logic [ID_W-1:0]   next_ident;
    t_verdict          verdict_fifo [FIFO_DEPTH];
    int                fifo_wr;
    int                fifo_rd;

    function automatic t_verdict apply_command(input t_cmd cmd, input logic [1:0] kind,
                                               input logic [PORT_W-1:0] key_a,
                                               input logic [PORT_W-1:0] key_b,
                                               input logic allow, input logic [ID_W-1:0] rid);
        t_verdict v;
        logic     found;
        logic     either_way;
        int       i;
        v          = '0;
        found      = 1'b0;
        either_way = (kind == KIND_FF) || (kind == KIND_PP);
        case (cmd)
            CMD_ADD: begin
                if (rule_count >= TABLE_DEPTH) begin
                    v.status = ST_FULL;
                end else begin
                    rule_kind[rule_count]  = kind;
                    rule_key_a[rule_count] = key_a;
                    rule_key_b[rule_count] = key_b;
                    rule_allow[rule_count] = allow;
                    rule_ident[rule_count] = next_ident;
                    v.new_id   = next_ident;
                    next_ident = next_ident + ID_W'(1);
                    rule_count = rule_count + 1;
                end
            end
            CMD_REMOVE: begin
                for (i = 0; i < rule_count; i++) begin
                    if (!found && rule_ident[i] == rid)
                        found = 1'b1;
                    if (found && i + 1 < rule_count) begin
                        rule_kind[i]  = rule_kind[i + 1];
                        rule_key_a[i] = rule_key_a[i + 1];
                        rule_key_b[i] = rule_key_b[i + 1];
                        rule_allow[i] = rule_allow[i + 1];
                        rule_ident[i] = rule_ident[i + 1];
                    end
                end
                if (found) begin
                    rule_count = rule_count - 1;
                    v.status   = ST_OK;
                end else begin
                    v.status = ST_NOT_FOUND;
                end
            end
            CMD_QUERY: begin
                v.collide = (kind == KIND_FF);
                for (i = 0; i < rule_count; i++) begin
                    if (!v.matched && rule_kind[i] == kind &&
                        ((rule_key_a[i] == key_a && rule_key_b[i] == key_b) ||
                         (either_way && rule_key_a[i] == key_b && rule_key_b[i] == key_a))) begin
                        v.matched = 1'b1;
                        v.collide = rule_allow[i];
                    end
                end
            end
            default: begin
                rule_count = 0;
            end
        endcase
        return v;
    endfunction

    task automatic compare_field(input string name, input logic [ID_W-1:0] want,
                                 input logic [ID_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            rule_count   = 0;
            next_ident   = ID_W'(1);
            o_fail_count = 0;
            fifo_wr      = 0;
            fifo_rd      = 0;
        end else begin
            if (i_valid) begin
                got = {i_new_id, i_collide, i_matched, i_status};
                if (fifo_wr == fifo_rd) begin
                    $display("%0t: result with none expected, expected none, actual %h",
                             $time, got);
                    o_fail_count++;
                end else begin
                    want    = verdict_fifo[fifo_rd % FIFO_DEPTH];
                    fifo_rd = fifo_rd + 1;
                    compare_field("new_id", want.new_id, got.new_id);
                    compare_field("collide", ID_W'(want.collide), ID_W'(got.collide));
                    compare_field("matched", ID_W'(want.matched), ID_W'(got.matched));
                    compare_field("status", ID_W'(want.status), ID_W'(got.status));
                end
            end
            if (i_start && !i_busy) begin
                verdict_fifo[fifo_wr % FIFO_DEPTH] =
                    apply_command(t_cmd'(i_cmd), i_kind, i_key_a, i_key_b, i_allow, i_rule_id);
                fifo_wr = fifo_wr + 1;
            end
        end
        o_pending = fifo_wr - fifo_rd;
    end

endmodule

>>> verif/pair_collision_filter_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pair collision filter table testbench
// Drives directed and random rule table commands with random idle gaps and
// leaves prediction and checking of every result to the checker beside the
// block.
// ----------------------------------------------------------------------------
module pair_collision_filter_table_tb;
    import pcft_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [1:0] KIND_FP  = 2'd1;
    localparam logic [1:0] KIND_ODD = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_cmd;
    logic [1:0]        i_kind;
    logic [PORT_W-1:0] i_key_a;
    logic [PORT_W-1:0] i_key_b;
    logic              i_allow;
    logic [ID_W-1:0]   i_rule_id;
    logic              o_valid;
    logic [ID_W-1:0]   o_new_id;
    logic              o_collide;
    logic              o_matched;
    logic [1:0]        o_status;
    int                fail_count;
    int                pending;
    int                cycle_count;

    logic              idle_on;
    int                adds_sent;
    int                pool_n;
    int                pool_wr;
    logic [1:0]        pool_kind [TABLE_DEPTH];
    logic [PORT_W-1:0] pool_a    [TABLE_DEPTH];
    logic [PORT_W-1:0] pool_b    [TABLE_DEPTH];

    pair_collision_filter_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(i_cmd),
        .i_kind(i_kind),
        .i_key_a(i_key_a),
        .i_key_b(i_key_b),
        .i_allow(i_allow),
        .i_rule_id(i_rule_id),
        .o_valid(o_valid),
        .o_new_id(o_new_id),
        .o_collide(o_collide),
        .o_matched(o_matched),
        .o_status(o_status)
    );

    pair_collision_filter_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_cmd(i_cmd),
        .i_kind(i_kind),
        .i_key_a(i_key_a),
        .i_key_b(i_key_b),
        .i_allow(i_allow),
        .i_rule_id(i_rule_id),
        .i_valid(o_valid),
        .i_new_id(o_new_id),
        .i_collide(o_collide),
        .i_matched(o_matched),
        .i_status(o_status),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input t_cmd cmd, input logic [1:0] kind,
                             input logic [PORT_W-1:0] key_a, input logic [PORT_W-1:0] key_b,
                             input logic allow, input logic [ID_W-1:0] rid);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            start = 1'b0;
            while (busy)
                @(negedge i_clk);
            repeat (gap - 1) @(negedge i_clk);
        end
        i_cmd     = cmd;
        i_kind    = kind;
        i_key_a   = key_a;
        i_key_b   = key_b;
        i_allow   = allow;
        i_rule_id = rid;
        start     = 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        if (cmd == CMD_ADD) begin
            adds_sent++;
            pool_kind[pool_wr] = kind;
            pool_a[pool_wr]    = key_a;
            pool_b[pool_wr]    = key_b;
            pool_wr            = (pool_wr + 1) % TABLE_DEPTH;
            if (pool_n < TABLE_DEPTH)
                pool_n++;
        end
    endtask

    // Keys are mostly drawn from a narrow range or from rules added earlier,
    // so that queries hit stored rules and removes hit live ids often.
    task automatic random_item(input int add_pct);
        int                pick;
        int                slot;
        logic [1:0]        kind;
        logic [PORT_W-1:0] key_a;
        logic [PORT_W-1:0] key_b;
        logic [ID_W-1:0]   rid;
        pick  = $urandom_range(0, 99);
        kind  = 2'($urandom);
        key_a = ($urandom_range(0, 1) == 0) ? PORT_W'($urandom_range(0, 7)) : PORT_W'($urandom);
        key_b = ($urandom_range(0, 1) == 0) ? PORT_W'($urandom_range(0, 7)) : PORT_W'($urandom);
        rid   = ID_W'($urandom);
        if (pick < add_pct) begin
            send_item(CMD_ADD, kind, key_a, key_b, 1'($urandom), rid);
        end else if (pick < add_pct + 15) begin
            if ($urandom_range(0, 4) != 0)
                rid = ID_W'(adds_sent + 1 - $urandom_range(0, 20));
            send_item(CMD_REMOVE, kind, key_a, key_b, 1'($urandom), rid);
        end else if (pick < add_pct + 17) begin
            send_item(CMD_CLEAR, kind, key_a, key_b, 1'($urandom), rid);
        end else begin
            if (pool_n != 0 && $urandom_range(0, 9) < 7) begin
                slot = $urandom_range(0, pool_n - 1);
                if ($urandom_range(0, 3) != 0)
                    kind = pool_kind[slot];
                if ($urandom_range(0, 1) == 0) begin
                    key_a = pool_a[slot];
                    key_b = pool_b[slot];
                end else begin
                    key_a = pool_b[slot];
                    key_b = pool_a[slot];
                end
            end
            send_item(CMD_QUERY, kind, key_a, key_b, 1'($urandom), rid);
        end
    endtask

    initial begin
        int add_pct;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_cmd     = CMD_ADD;
        i_kind    = KIND_FF;
        i_key_a   = '0;
        i_key_b   = '0;
        i_allow   = 1'b0;
        i_rule_id = '0;
        idle_on   = 1'b1;
        adds_sent = 0;
        pool_n    = 0;
        pool_wr   = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Defaults of every kind on an empty table, and a remove of an id never given.
        send_item(CMD_QUERY, KIND_FF, 16'h0000, 16'hFFFF, 1'b0, 16'h0000);
        send_item(CMD_QUERY, KIND_FP, 16'h0000, 16'hFFFF, 1'b1, 16'h0000);
        send_item(CMD_QUERY, KIND_PP, 16'hFFFF, 16'h0000, 1'b0, 16'hFFFF);
        send_item(CMD_QUERY, KIND_ODD, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
        send_item(CMD_REMOVE, KIND_FF, 16'h0000, 16'h0000, 1'b0, 16'h0000);
        // One rule of each kind, then forward, swapped and cross-kind lookups.
        send_item(CMD_ADD, KIND_FF, 16'h0000, 16'hFFFF, 1'b0, 16'h0000);
        send_item(CMD_ADD, KIND_FP, 16'h1234, 16'hABCD, 1'b1, 16'hFFFF);
        send_item(CMD_ADD, KIND_PP, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000);
        send_item(CMD_ADD, KIND_ODD, 16'h0005, 16'h0006, 1'b1, 16'h0000);
        send_item(CMD_QUERY, KIND_FF, 16'h0000, 16'hFFFF, 1'b1, 16'h0000);
        send_item(CMD_QUERY, KIND_FF, 16'hFFFF, 16'h0000, 1'b1, 16'h0000);
        send_item(CMD_QUERY, KIND_FP, 16'h1234, 16'hABCD, 1'b0, 16'h0000);
        send_item(CMD_QUERY, KIND_FP, 16'hABCD, 16'h1234, 1'b0, 16'h0000);
        send_item(CMD_QUERY, KIND_PP, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000);
        send_item(CMD_QUERY, KIND_ODD, 16'h0005, 16'h0006, 1'b0, 16'h0000);
        send_item(CMD_QUERY, KIND_ODD, 16'h0006, 16'h0005, 1'b0, 16'h0000);
        send_item(CMD_QUERY, KIND_FP, 16'h0000, 16'hFFFF, 1'b0, 16'h0000);
        // A later duplicate loses to the first rule until that one is removed.
        send_item(CMD_ADD, KIND_FF, 16'hFFFF, 16'h0000, 1'b1, 16'h0000);
        send_item(CMD_QUERY, KIND_FF, 16'hFFFF, 16'h0000, 1'b1, 16'h0000);
        send_item(CMD_REMOVE, KIND_FF, 16'h0000, 16'h0000, 1'b0, 16'h0001);
        send_item(CMD_QUERY, KIND_FF, 16'h0000, 16'hFFFF, 1'b0, 16'h0000);
        send_item(CMD_REMOVE, KIND_FF, 16'h0000, 16'h0000, 1'b0, 16'h0001);
        send_item(CMD_REMOVE, KIND_FF, 16'h0000, 16'h0000, 1'b0, 16'hFFFF);
        send_item(CMD_CLEAR, KIND_FF, 16'h0000, 16'h0000, 1'b0, 16'h0000);
        send_item(CMD_QUERY, KIND_PP, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000);

        // Each burst picks its add share at random, so some fill the table past full and others mostly query it.
        repeat (46) begin
            case ($urandom_range(0, 2))
                0: add_pct = 20;
                1: add_pct = 40;
                default: add_pct = 70;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (40) random_item(add_pct);
        end

        idle_on = 1'b1;
        repeat (20) random_item(40);

        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (2 * TABLE_DEPTH + 4) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
